// ----- rtl/gisg_pkg.sv -----
// Package for the GNSS IF sample generator: beat types, codes, defaults
// and the elaboration-time quarter-wave sine table builder.
// No dependencies.
package gisg_pkg;

    localparam int PRN_DEPTH_DEF      = 16384;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS        = 24;

    localparam logic [14:0] CODE_LEN_RESET = 15'd1023;
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [63:0] SERIES_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

    typedef enum logic [2:0] {
        MODE_LOAD_DATA  = 3'd0,
        MODE_LOAD_PILOT = 3'd1,
        MODE_START      = 3'd2,
        MODE_DATA_SIG   = 3'd3,
        MODE_PILOT_SIG  = 3'd4,
        MODE_SAMPLE     = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        REG_DATA_LEN  = 2'd0,
        REG_PILOT_LEN = 2'd1,
        REG_PILOT_EN  = 2'd2,
        REG_HALF_EN   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_READ,
        S_VEC,
        S_CPLX,
        S_GAIN,
        S_ROUND,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        JOB_START_D,
        JOB_START_P,
        JOB_OLD_D,
        JOB_OLD_P,
        JOB_NEW_D,
        JOB_NEW_P
    } t_job;

    typedef struct packed {
        logic [2:0]         mode;
        logic [13:0]        chip_address;
        logic               chip_bit;
        logic [31:0]        carrier_start;
        logic signed [31:0] carrier_step;
        logic [37:0]        code_start;
        logic [27:0]        code_step;
        logic [15:0]        amplitude;
        logic signed [15:0] signal_real;
        logic signed [15:0] signal_imag;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_real;
        logic signed [SAMPLE_BITS-1:0] sample_imag;
        logic                          period_wrapped;
    } t_out_item;

    function automatic logic [15:0] sine_entry(input int unsigned k,
                                               input int unsigned addr_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        scaled;
        x    = (HALF_PI_Q30 * 64'(k)) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        acc  = signed'(x);
        for (int n = 0; n < 7; n++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[n];
            if (n[0] == 1'b0) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        if (acc < 0) begin
            acc = 64'sd0;
        end
        scaled = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
        if (scaled > 64'd32767) begin
            scaled = 64'd32767;
        end
        return scaled[15:0];
    endfunction

endpackage

// ----- rtl/gisg_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gisg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gnss_if_sample_generator_top.sv -----
// GNSS IF sample generator, top level: APB register file, sequencer,
// shared remainder unit and sample datapath.
// Depends on gisg_pkg and gisg_ram (data and pilot PRN chip memories).
//
// Usage: load the data and pilot PRN chips (one chip per input beat), write the
// modulation values, send a block-start beat, then send sample beats; each
// sample beat gives one output beat, every other beat gives none.
// Input channel i_in_valid/o_in_ready, output channel o_out_valid/i_out_ready.
// Chip load and modulation beats are handled as they are taken. A block start
// takes the start chip modulo the data, then the pilot code length, one
// quotient bit per cycle in the shared remainder unit. A sample reduces the
// old indexes, reads the PRN memories once in the read step (their registered
// bits feed the vector step after it), forms the product, gain and rounded
// result and reduces the new indexes. The result sits in an output register;
// the next beat is taken while it waits, and a sample stalls in its last step
// only if the previous result has not been taken. Reset (synchronous) clears
// the phase, code and modulation state and sets the code lengths to 1023; the
// PRN memories are not cleared and must be loaded before use.
module gnss_if_sample_generator_top #(
    parameter int PRN_DEPTH         = gisg_pkg::PRN_DEPTH_DEF,
    parameter int SINE_ADDRESS_BITS = gisg_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gisg_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gisg_pkg::t_out_item o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import gisg_pkg::*;

    localparam int AW      = $clog2(PRN_DEPTH);
    localparam int LW      = AW + 1;
    localparam int VW      = ((AW > 14) ? AW : 14) + 1;
    localparam int MW      = VW + LW;
    localparam int SW      = $clog2(VW);
    localparam int SAB     = SINE_ADDRESS_BITS;
    localparam int QUARTER = 1 << (SAB - 2);
    localparam int QW      = SAB - 1;
    localparam int OS      = 48 - SAMPLE_BITS;
    localparam int YW      = 53;

    localparam logic signed [YW-1:0] ROUND_HALF = YW'(64'sd1 <<< (OS - 1));
    localparam logic signed [YW-1:0] SAT_HI     = YW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [YW-1:0] SAT_LO     = ~SAT_HI;

    t_state n_state;
    t_state r_state;
    t_job   r_job;

    logic [14:0] r_dlen_cfg;
    logic [14:0] r_plen_cfg;
    logic        r_pen;
    logic        r_hce;

    logic [31:0]    r_phase;
    logic [31:0]    r_cinc;
    logic [23:0]    r_frac;
    logic [27:0]    r_finc;
    logic [AW-1:0]  r_didx;
    logic [AW-1:0]  r_pidx;
    logic           r_half;
    logic [15:0]    r_gain;
    logic [31:0]    r_dmod;
    logic [31:0]    r_pmod;

    logic [13:0]    r_chip;
    logic [VW-1:0]  r_rem;
    logic [LW-1:0]  r_dvs;
    logic [SW-1:0]  r_sh;
    logic [AW-1:0]  r_dold;
    logic [AW-1:0]  r_pold;
    logic [4:0]     r_carry;
    logic           r_wrap;

    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;
    logic signed [17:0] r_vr;
    logic signed [17:0] r_vi;
    logic signed [33:0] r_p_rc;
    logic signed [33:0] r_p_is;
    logic signed [33:0] r_p_rs;
    logic signed [33:0] r_p_ic;
    logic signed [51:0] r_re;
    logic signed [51:0] r_im;
    logic signed [SAMPLE_BITS-1:0] r_res_re;
    logic signed [SAMPLE_BITS-1:0] r_res_im;
    logic       r_out_valid;
    t_out_item  r_out;

    logic signed [15:0] w_sine_tab [QUARTER+1];

    logic            w_in_acc;
    logic            w_cfg_wr;
    logic            w_addr_ok;
    logic            w_dram_we;
    logic            w_pram_we;
    logic            w_ram_re;
    logic            w_out_load;
    logic [AW-1:0]   w_waddr;
    logic            w_dbit;
    logic            w_pbit;
    logic [LW-1:0]   w_dlen;
    logic [LW-1:0]   w_plen;
    logic            w_mod_done;
    logic [MW-1:0]   w_mod_shifted;
    logic            w_mod_ge;
    logic [SAB-1:0]  w_sidx;
    logic [SAB-1:0]  w_cidx;
    logic signed [17:0] w_dr;
    logic signed [17:0] w_di;
    logic signed [17:0] w_pr;
    logic signed [17:0] w_pi;
    logic signed [17:0] w_vr;
    logic signed [17:0] w_vi;
    logic signed [34:0] w_diff_re;
    logic signed [34:0] w_sum_im;
    logic signed [51:0] w_gain_s;
    logic signed [YW-1:0] w_y_re;
    logic signed [YW-1:0] w_y_im;
    logic [28:0]     w_code_sum;

    for (genvar k = 0; k <= QUARTER; k++) begin : g_sine
        localparam logic [15:0] Entry = sine_entry(k, SINE_ADDRESS_BITS);
        assign w_sine_tab[k] = signed'(Entry);
    end

    function automatic logic [LW-1:0] eff_len(input logic [14:0] len);
        if (len == 15'd0) begin
            return LW'(1);
        end
        if (32'(len) > 32'(PRN_DEPTH)) begin
            return LW'(PRN_DEPTH);
        end
        return LW'(len);
    endfunction

    function automatic logic signed [15:0] sine_at(input logic [SAB-1:0] idx);
        logic [1:0]         quad;
        logic [QW-1:0]      off;
        logic [QW-1:0]      addr;
        logic signed [15:0] v;
        quad = idx[SAB-1 -: 2];
        off  = QW'(idx[SAB-3:0]);
        addr = quad[0] ? (QW'(QUARTER) - off) : off;
        v    = w_sine_tab[addr];
        return quad[1] ? -v : v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] saturate(input logic signed [YW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[SAMPLE_BITS-1:0];
        end
        if (v < SAT_LO) begin
            return SAT_LO[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_addr_ok = 32'(i_in.chip_address) < 32'(PRN_DEPTH);
    assign w_waddr   = AW'(32'(i_in.chip_address));
    assign w_dlen    = eff_len(r_dlen_cfg);
    assign w_plen    = eff_len(r_plen_cfg);

    assign w_mod_done    = MW'(r_rem) < MW'(r_dvs);
    assign w_mod_shifted = MW'(r_dvs) << r_sh;
    assign w_mod_ge      = MW'(r_rem) >= w_mod_shifted;

    assign w_sidx = r_phase[31 -: SAB];
    assign w_cidx = w_sidx + SAB'(QUARTER);

    assign w_dr = w_dbit ? -18'(signed'(r_dmod[31:16])) : 18'(signed'(r_dmod[31:16]));
    assign w_di = w_dbit ? -18'(signed'(r_dmod[15:0]))  : 18'(signed'(r_dmod[15:0]));
    assign w_pr = w_pbit ? -18'(signed'(r_pmod[31:16])) : 18'(signed'(r_pmod[31:16]));
    assign w_pi = w_pbit ? -18'(signed'(r_pmod[15:0]))  : 18'(signed'(r_pmod[15:0]));
    assign w_vr = r_pen ? (w_dr + w_pr) : w_dr;
    assign w_vi = r_pen ? (w_di + w_pi) : w_di;

    assign w_diff_re = 35'(r_p_rc) - 35'(r_p_is);
    assign w_sum_im  = 35'(r_p_rs) + 35'(r_p_ic);
    assign w_gain_s  = 52'(signed'({1'b0, r_gain}));

    assign w_y_re     = 53'(r_re) + ROUND_HALF;
    assign w_y_im     = 53'(r_im) + ROUND_HALF;
    assign w_code_sum = 29'(r_frac) + 29'(r_finc);

    gisg_ram #(
        .WIDTH (1),
        .DEPTH (PRN_DEPTH)
    ) u_data_prn (
        .i_clk   (i_clk),
        .i_we    (w_dram_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.chip_bit),
        .i_re    (w_ram_re),
        .i_raddr (r_dold),
        .o_rdata (w_dbit)
    );

    gisg_ram #(
        .WIDTH (1),
        .DEPTH (PRN_DEPTH)
    ) u_pilot_prn (
        .i_clk   (i_clk),
        .i_we    (w_pram_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.chip_bit),
        .i_re    (w_ram_re),
        .i_raddr (r_pold),
        .o_rdata (w_pbit)
    );

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_DATA_LEN:  prdata = {17'd0, r_dlen_cfg};
            REG_PILOT_LEN: prdata = {17'd0, r_plen_cfg};
            REG_PILOT_EN:  prdata = {31'd0, r_pen};
            REG_HALF_EN:   prdata = {31'd0, r_hce};
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in.mode == MODE_START || i_in.mode == MODE_SAMPLE)) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    case (r_job)
                        JOB_START_P: n_state = S_IDLE;
                        JOB_OLD_P:   n_state = S_READ;
                        JOB_NEW_P:   n_state = S_OUT;
                        default:     n_state = S_MOD;
                    endcase
                end
            end
            S_READ:  n_state = S_VEC;
            S_VEC:   n_state = S_CPLX;
            S_CPLX:  n_state = S_GAIN;
            S_GAIN:  n_state = S_ROUND;
            S_ROUND: n_state = S_MOD;
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_dram_we  = 1'b0;
        w_pram_we  = 1'b0;
        w_ram_re   = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_dram_we  = i_in_valid && w_addr_ok && (i_in.mode == MODE_LOAD_DATA);
                w_pram_we  = i_in_valid && w_addr_ok && (i_in.mode == MODE_LOAD_PILOT);
            end
            S_READ: w_ram_re = 1'b1;
            S_OUT:  w_out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= JOB_START_D;
            r_dlen_cfg  <= CODE_LEN_RESET;
            r_plen_cfg  <= CODE_LEN_RESET;
            r_pen       <= 1'b0;
            r_hce       <= 1'b0;
            r_phase     <= '0;
            r_cinc      <= '0;
            r_frac      <= '0;
            r_finc      <= '0;
            r_didx      <= '0;
            r_pidx      <= '0;
            r_half      <= 1'b0;
            r_gain      <= '0;
            r_dmod      <= '0;
            r_pmod      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                unique case (t_reg_idx'(paddr[3:2]))
                    REG_DATA_LEN:  r_dlen_cfg <= pwdata[14:0];
                    REG_PILOT_LEN: r_plen_cfg <= pwdata[14:0];
                    REG_PILOT_EN:  r_pen      <= pwdata[0];
                    REG_HALF_EN:   r_hce      <= pwdata[0];
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in.mode)
                            MODE_START: begin
                                r_phase <= i_in.carrier_start +
                                           ((r_hce && r_half) ? 32'h8000_0000 : 32'h0);
                                if (r_hce) begin
                                    r_half <= ~r_half;
                                end
                                r_cinc <= i_in.carrier_step;
                                r_frac <= i_in.code_start[23:0];
                                r_finc <= i_in.code_step;
                                r_gain <= i_in.amplitude;
                                r_chip <= i_in.code_start[37:24];
                                r_rem  <= VW'(i_in.code_start[37:24]);
                                r_dvs  <= w_dlen;
                                r_sh   <= SW'(VW - 1);
                                r_job  <= JOB_START_D;
                            end
                            MODE_DATA_SIG:  r_dmod <= {i_in.signal_real, i_in.signal_imag};
                            MODE_PILOT_SIG: r_pmod <= {i_in.signal_real, i_in.signal_imag};
                            MODE_SAMPLE: begin
                                r_rem <= VW'(r_didx);
                                r_dvs <= w_dlen;
                                r_sh  <= SW'(VW - 1);
                                r_job <= JOB_OLD_D;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        case (r_job)
                            JOB_START_D: begin
                                r_didx <= AW'(r_rem);
                                r_rem  <= VW'(r_chip);
                                r_dvs  <= w_plen;
                                r_sh   <= SW'(VW - 1);
                                r_job  <= JOB_START_P;
                            end
                            JOB_START_P: r_pidx <= AW'(r_rem);
                            JOB_OLD_D: begin
                                r_dold <= AW'(r_rem);
                                r_rem  <= VW'(r_pidx);
                                r_dvs  <= w_plen;
                                r_sh   <= SW'(VW - 1);
                                r_job  <= JOB_OLD_P;
                            end
                            JOB_OLD_P: r_pold <= AW'(r_rem);
                            JOB_NEW_D: begin
                                r_didx <= AW'(r_rem);
                                r_wrap <= AW'(r_rem) < r_dold;
                                r_rem  <= VW'(r_pold) + VW'(r_carry);
                                r_dvs  <= w_plen;
                                r_sh   <= SW'(VW - 1);
                                r_job  <= JOB_NEW_P;
                            end
                            JOB_NEW_P: r_pidx <= AW'(r_rem);
                            default: ;
                        endcase
                    end else begin
                        if (w_mod_ge) begin
                            r_rem <= r_rem - VW'(w_mod_shifted);
                        end
                        if (r_sh != '0) begin
                            r_sh <= r_sh - SW'(1);
                        end
                    end
                end
                S_READ: begin
                    r_sin <= sine_at(w_sidx);
                    r_cos <= sine_at(w_cidx);
                end
                S_VEC: begin
                    r_vr <= w_vr;
                    r_vi <= w_vi;
                end
                S_CPLX: begin
                    r_p_rc <= 34'(r_vr) * 34'(r_cos);
                    r_p_is <= 34'(r_vi) * 34'(r_sin);
                    r_p_rs <= 34'(r_vr) * 34'(r_sin);
                    r_p_ic <= 34'(r_vi) * 34'(r_cos);
                end
                S_GAIN: begin
                    r_re <= 52'(w_diff_re) * w_gain_s;
                    r_im <= 52'(w_sum_im) * w_gain_s;
                end
                S_ROUND: begin
                    r_res_re <= saturate(w_y_re >>> OS);
                    r_res_im <= saturate(w_y_im >>> OS);
                    r_phase  <= r_phase + r_cinc;
                    r_frac   <= w_code_sum[23:0];
                    r_carry  <= w_code_sum[28:24];
                    r_rem    <= VW'(r_dold) + VW'(w_code_sum[28:24]);
                    r_dvs    <= w_dlen;
                    r_sh     <= SW'(VW - 1);
                    r_job    <= JOB_NEW_D;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out.sample_real    <= r_res_re;
                        r_out.sample_imag    <= r_res_im;
                        r_out.period_wrapped <= r_wrap;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- sim/gnss_if_sample_generator_top_tb.sv -----
// Testbench for gnss_if_sample_generator_top: random and directed beats against
// a cycle-free predictor of the IF samples, checked field by field.
// Depends on gisg_pkg and the RTL of the generator.
module gnss_if_sample_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gisg_pkg::*;

    localparam int          PRN_CHIPS    = PRN_DEPTH_DEF;
    localparam int          SINE_BITS    = SINE_ADDR_BITS_DEF;
    localparam int unsigned QUARTER_WAVE = 1 << (SINE_BITS - 2);
    localparam int          OUT_SHIFT    = 48 - SAMPLE_BITS;
    localparam longint      SAT_MAX      = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint      SAT_MIN      = -SAT_MAX - 1;
    localparam int unsigned CHIP_SPAN    = 192;
    localparam int unsigned SMALL_SPAN   = 128;
    localparam int unsigned START_REACH  = 32;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam longint unsigned CYCLE_LIMIT = 1000000;
    localparam logic [2:0]  MODE_SPARE_LO = 3'd6;
    localparam logic [2:0]  MODE_SPARE_HI = 3'd7;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    gnss_if_sample_generator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // register shadow
    logic [14:0] cfg_data_len  = CODE_LEN_RESET;
    logic [14:0] cfg_pilot_len = CODE_LEN_RESET;
    logic        cfg_pilot_en  = 1'b0;
    logic        cfg_half_en   = 1'b0;

    // generator state
    logic [31:0]        phase_acc  = '0;
    logic [31:0]        phase_step = '0;
    logic [23:0]        code_frac  = '0;
    logic [27:0]        code_inc   = '0;
    int unsigned        data_idx   = 0;
    int unsigned        pilot_idx  = 0;
    logic               half_flag  = 1'b0;
    int                 gain_q     = 0;
    logic signed [15:0] data_re    = '0;
    logic signed [15:0] data_im    = '0;
    logic signed [15:0] pilot_re   = '0;
    logic signed [15:0] pilot_im   = '0;
    bit                 data_chips  [PRN_CHIPS];
    bit                 pilot_chips [PRN_CHIPS];
    int                 sine_q [QUARTER_WAVE + 1];

    t_in_item    stim_beats[$];
    t_out_item   want_samples[$];
    int unsigned beats_queued     = 0;
    int unsigned beats_taken      = 0;
    int unsigned gen_count        = 0;
    int unsigned samples_seen     = 0;
    int unsigned mismatch_count   = 0;
    int unsigned settings_applied = 0;
    int unsigned send_gap         = 0;
    int unsigned recv_hold        = 0;
    logic        no_idle          = 1'b0;
    logic        hold_request     = 1'b0;
    logic        hold_taken       = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void fill_sine_quarter();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        int unsigned     k;
        int unsigned     n;
        for (k = 0; k <= QUARTER_WAVE; k++) begin
            x    = (HALF_PI_Q30 * k) / QUARTER_WAVE;
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            acc = (acc * 32767 + (longint'(1) << 29)) >>> 30;
            if (acc > 32767) begin
                acc = 32767;
            end
            sine_q[k] = int'(acc);
        end
    endfunction

    function automatic int sine_of(input int unsigned idx);
        int unsigned quad;
        int unsigned off;
        int          v;
        quad = (idx >> (SINE_BITS - 2)) & 3;
        off  = idx & (QUARTER_WAVE - 1);
        v    = quad[0] ? sine_q[QUARTER_WAVE - off] : sine_q[off];
        return quad[1] ? -v : v;
    endfunction

    function automatic int unsigned effective_len(input logic [14:0] len);
        if (len == 0) begin
            return 1;
        end
        return (len > PRN_CHIPS) ? PRN_CHIPS : len;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input longint v);
        longint r;
        r = (v + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (r > SAT_MAX) begin
            r = SAT_MAX;
        end else if (r < SAT_MIN) begin
            r = SAT_MIN;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic void model_item(input t_in_item it);
        int unsigned dlen;
        int unsigned plen;
        int unsigned d_old;
        int unsigned p_old;
        int unsigned d_new;
        int unsigned idx;
        int unsigned code_sum;
        logic [13:0] chip;
        longint      vr;
        longint      vi;
        longint      pr;
        longint      pq;
        longint      re;
        longint      im;
        int          sn;
        int          cv;
        t_out_item   res;
        dlen = effective_len(cfg_data_len);
        plen = effective_len(cfg_pilot_len);
        case (it.mode)
            MODE_LOAD_DATA: begin
                data_chips[it.chip_address] = it.chip_bit;
            end
            MODE_LOAD_PILOT: begin
                pilot_chips[it.chip_address] = it.chip_bit;
            end
            MODE_START: begin
                chip      = it.code_start[37:24];
                phase_acc = it.carrier_start;
                if (cfg_half_en) begin
                    if (half_flag) begin
                        phase_acc = phase_acc + 32'h8000_0000;
                    end
                    half_flag = ~half_flag;
                end
                phase_step = it.carrier_step;
                code_frac  = it.code_start[23:0];
                code_inc   = it.code_step;
                data_idx   = chip % dlen;
                pilot_idx  = chip % plen;
                gain_q     = it.amplitude;
            end
            MODE_DATA_SIG: begin
                data_re = it.signal_real;
                data_im = it.signal_imag;
            end
            MODE_PILOT_SIG: begin
                pilot_re = it.signal_real;
                pilot_im = it.signal_imag;
            end
            MODE_SAMPLE: begin
                d_old = data_idx % dlen;
                p_old = pilot_idx % plen;
                vr    = data_re;
                vi    = data_im;
                if (data_chips[d_old]) begin
                    vr = -vr;
                    vi = -vi;
                end
                if (cfg_pilot_en) begin
                    pr = pilot_re;
                    pq = pilot_im;
                    if (pilot_chips[p_old]) begin
                        pr = -pr;
                        pq = -pq;
                    end
                    vr = vr + pr;
                    vi = vi + pq;
                end
                idx = phase_acc[31:32-SINE_BITS];
                sn  = sine_of(idx);
                cv  = sine_of(idx + QUARTER_WAVE);
                re  = (vr * cv - vi * sn) * gain_q;
                im  = (vr * sn + vi * cv) * gain_q;
                res.sample_real = to_sample(re);
                res.sample_imag = to_sample(im);
                phase_acc = phase_acc + phase_step;
                code_sum  = code_frac + code_inc;
                code_frac = code_sum[23:0];
                d_new     = (d_old + (code_sum >> 24)) % dlen;
                data_idx  = d_new;
                pilot_idx = (p_old + (code_sum >> 24)) % plen;
                res.period_wrapped = (d_new < d_old);
                want_samples.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void note_mismatch(input string what, input logic [23:0] want,
                                          input logic [23:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch on %s, sample %0d: expected %h, got %h",
                     what, samples_seen, want, got);
        end
    endfunction

    function automatic void check_sample(input t_out_item got);
        t_out_item want;
        if (want_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("Sample beat with nothing pending: %h", got);
            end
            return;
        end
        want = want_samples.pop_front();
        if (got.sample_real !== want.sample_real) begin
            note_mismatch("sample_real", want.sample_real, got.sample_real);
        end
        if (got.sample_imag !== want.sample_imag) begin
            note_mismatch("sample_imag", want.sample_imag, got.sample_imag);
        end
        if (got.period_wrapped !== want.period_wrapped) begin
            note_mismatch("period_wrapped", want.period_wrapped, got.period_wrapped);
        end
        samples_seen++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                model_item(i_in);
                beats_taken++;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the beat until taken
            end else if (send_gap != 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (stim_beats.size() != 0) begin
                i_in       <= stim_beats.pop_front();
                i_in_valid <= 1'b1;
                send_gap   <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : receive
        int unsigned stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_hold   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_sample(o_out);
            end
            if (hold_request && !hold_taken) begin
                hold_taken  <= 1'b1;
                recv_hold   <= HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (recv_hold != 0) begin
                recv_hold   <= recv_hold - 1;
                i_out_ready <= 1'b0;
            end else begin
                stall        = pick_gap();
                i_out_ready <= (stall == 0);
                recv_hold   <= (stall == 0) ? 0 : stall - 1;
            end
        end
    end

    initial begin : watchdog
        longint unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles", cycles);
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DATA_LEN: begin
                cfg_data_len = value[14:0];
            end
            REG_PILOT_LEN: begin
                cfg_pilot_len = value[14:0];
            end
            REG_PILOT_EN: begin
                cfg_pilot_en = value[0];
            end
            REG_HALF_EN: begin
                cfg_half_en = value[0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic apply_setting(input logic [14:0] dl, input logic [14:0] pl,
                                 input logic pe, input logic he);
        write_reg(REG_DATA_LEN, {17'd0, dl});
        write_reg(REG_PILOT_LEN, {17'd0, pl});
        write_reg(REG_PILOT_EN, {31'd0, pe});
        write_reg(REG_HALF_EN, {31'd0, he});
        settings_applied++;
    endtask

    task automatic drain();
        while (beats_taken != beats_queued || want_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_beat(input t_in_item b);
        stim_beats.push_back(b);
        beats_queued++;
        if (b.mode < MODE_SPARE_LO) begin
            gen_count++;
        end
    endfunction

    function automatic t_in_item random_beat(input logic [2:0] m);
        t_in_item b;
        b.mode          = m;
        b.chip_address  = 14'($urandom);
        b.chip_bit      = 1'($urandom);
        b.carrier_start = $urandom;
        b.carrier_step  = $urandom;
        b.code_start    = 38'({$urandom, $urandom});
        b.code_step     = 28'($urandom);
        b.amplitude     = 16'($urandom);
        b.signal_real   = 16'($urandom);
        b.signal_imag   = 16'($urandom);
        return b;
    endfunction

    function automatic t_in_item load_beat(input logic [2:0] m, input logic [13:0] addr,
                                           input logic level);
        t_in_item b;
        b              = random_beat(m);
        b.chip_address = addr;
        b.chip_bit     = level;
        return b;
    endfunction

    function automatic logic signed [15:0] pick_level();
        case ($urandom_range(0, 9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item mod_beat(input logic [2:0] m);
        t_in_item b;
        b             = random_beat(m);
        b.signal_real = pick_level();
        b.signal_imag = pick_level();
        return b;
    endfunction

    function automatic logic wide_code();
        return effective_len(cfg_data_len) > SMALL_SPAN ||
               effective_len(cfg_pilot_len) > SMALL_SPAN;
    endfunction

    // keep chip reads inside the loaded span when the code is long
    function automatic logic [13:0] pick_chip();
        logic [13:0] chip;
        int          tries;
        if (!wide_code()) begin
            return 14'($urandom);
        end
        for (tries = 0; tries < 64; tries++) begin
            chip = 14'($urandom);
            if (chip % effective_len(cfg_data_len) < START_REACH &&
                chip % effective_len(cfg_pilot_len) < START_REACH) begin
                return chip;
            end
        end
        return 14'($urandom_range(0, START_REACH - 1));
    endfunction

    function automatic t_in_item start_beat();
        t_in_item b;
        b                   = random_beat(MODE_START);
        b.code_start[37:24] = pick_chip();
        case ($urandom_range(0, 9))
            0: b.amplitude = 16'hFFFF;
            1: b.amplitude = 16'h0000;
            default: begin
            end
        endcase
        if ($urandom_range(0, 1)) begin
            b.code_step = 28'($urandom_range(0, 24'hFF_FFFF));
        end
        return b;
    endfunction

    function automatic void queue_start(input logic [31:0] cs, input logic [31:0] step,
                                        input logic [37:0] code, input logic [27:0] cstep,
                                        input logic [15:0] amp);
        t_in_item b;
        b               = random_beat(MODE_START);
        b.carrier_start = cs;
        b.carrier_step  = step;
        b.code_start    = code;
        b.code_step     = cstep;
        b.amplitude     = amp;
        queue_beat(b);
    endfunction

    function automatic void queue_signal(input logic [2:0] m, input logic signed [15:0] re,
                                         input logic signed [15:0] im);
        t_in_item b;
        b             = random_beat(m);
        b.signal_real = re;
        b.signal_imag = im;
        queue_beat(b);
    endfunction

    function automatic void queue_block();
        int unsigned n;
        int unsigned k;
        if ($urandom_range(0, 3) == 0) begin
            queue_beat(mod_beat(MODE_DATA_SIG));
        end
        if ($urandom_range(0, 3) == 0) begin
            queue_beat(mod_beat(MODE_PILOT_SIG));
        end
        queue_beat(start_beat());
        if ($urandom_range(0, 9) == 0) begin
            n = 0;
        end else if (wide_code()) begin
            n = $urandom_range(1, 8);
        end else begin
            n = $urandom_range(1, 40);
        end
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 29))
                0: queue_beat(mod_beat(MODE_DATA_SIG));
                1: queue_beat(mod_beat(MODE_PILOT_SIG));
                2: queue_beat(load_beat(MODE_LOAD_DATA, 14'($urandom_range(0, 1) ?
                                        $urandom_range(0, CHIP_SPAN - 1) : $urandom),
                                        1'($urandom)));
                3: queue_beat(load_beat(MODE_LOAD_PILOT, 14'($urandom_range(0, 1) ?
                                        $urandom_range(0, CHIP_SPAN - 1) : $urandom),
                                        1'($urandom)));
                4: queue_beat(random_beat($urandom_range(0, 1) ? MODE_SPARE_HI
                                                                : MODE_SPARE_LO));
                default: begin
                end
            endcase
            queue_beat(random_beat(MODE_SAMPLE));
        end
    endfunction

    task automatic run_phase(input logic [14:0] dl, input logic [14:0] pl, input logic pe,
                             input logic he, input int unsigned target,
                             input logic quiet, input logic squeeze);
        int unsigned first;
        apply_setting(dl, pl, pe, he);
        no_idle = quiet;
        first   = gen_count;
        repeat (2) queue_beat(random_beat(MODE_SAMPLE));
        while (gen_count - first < target) begin
            queue_block();
        end
        if (squeeze) begin
            hold_request = 1'b1;
        end
        drain();
        no_idle = 1'b0;
    endtask

    initial begin : stimulus
        int unsigned k;
        logic [14:0] dl;
        logic [14:0] pl;
        fill_sine_quarter();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < CHIP_SPAN; k++) begin
            queue_beat(load_beat(MODE_LOAD_DATA, 14'(k), 1'($urandom)));
            queue_beat(load_beat(MODE_LOAD_PILOT, 14'(k), 1'($urandom)));
        end

        queue_beat(random_beat(MODE_SAMPLE));
        queue_signal(MODE_DATA_SIG, 16'sd32767, -16'sd32768);
        queue_signal(MODE_PILOT_SIG, -16'sd32768, 16'sd32767);
        queue_start(32'h0000_0000, 32'h7FFF_FFFF, '1, '1, 16'hFFFF);
        repeat (3) queue_beat(random_beat(MODE_SAMPLE));
        queue_start(32'hFFFF_FFFF, 32'h8000_0000, '0, '0, 16'h0000);
        queue_beat(random_beat(MODE_SAMPLE));
        queue_signal(MODE_DATA_SIG, -16'sd32768, -16'sd32768);
        queue_start(32'h4000_0000, 32'h0000_0001, {14'd3, 24'hFF_FFFF}, 28'd1, 16'h0001);
        repeat (2) queue_beat(random_beat(MODE_SAMPLE));
        queue_beat(random_beat(MODE_SPARE_LO));
        queue_beat(random_beat(MODE_SPARE_HI));
        queue_beat(load_beat(MODE_LOAD_DATA, 14'h3FFF, 1'b1));
        queue_beat(load_beat(MODE_LOAD_PILOT, 14'h3FFF, 1'b0));
        queue_start(32'h2000_0000, 32'hFFFF_FFFF, '0, 28'h100_0000, 16'hFFFF);
        repeat (2) queue_beat(random_beat(MODE_SAMPLE));
        drain();

        run_phase(15'd0, 15'd0, 1'b1, 1'b1, 20, 1'b0, 1'b0);
        run_phase(15'd16384, 15'd32767, 1'b1, 1'b0, 20, 1'b0, 1'b0);
        run_phase(15'd3, 15'd12, 1'b1, 1'b1, 50, 1'b0, 1'b1);
        run_phase(15'd1, 15'd16384, 1'b0, 1'b1, 20, 1'b1, 1'b0);
        run_phase(15'd16385, 15'd1, 1'b1, 1'b1, 20, 1'b0, 1'b0);
        for (k = 0; k < 4; k++) begin
            dl = 15'($urandom_range(1, 32));
            pl = 15'(dl * $urandom_range(1, SMALL_SPAN / dl));
            run_phase(dl, pl, 1'($urandom), 1'($urandom), 15, 1'b0, 1'b0);
        end
        run_phase(CODE_LEN_RESET, CODE_LEN_RESET, 1'b0, 1'b0, 20, 1'b0, 1'b0);

        $display("Run covered %0d input beats and %0d checked samples over %0d settings,",
                 beats_taken, samples_seen, settings_applied + 1);
        $display("code lengths 0 to 32767, pilot and half-cycle on and off, one long stall.");
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gisg_pkg.sv
rtl/gisg_ram.sv
rtl/gnss_if_sample_generator_top.sv
sim/gnss_if_sample_generator_top_tb.sv
